// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_AT(lbl, clk, rst_n, !(cond))
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ----- hdl/bdhw_pkg.sv -----
`timescale 1ns / 1ps

package bdhw_pkg;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned CfgW     = 20;
  localparam int unsigned PhaseW   = 24;
  localparam int unsigned BeatW    = 20;
  localparam int unsigned SpeedW   = 16;
  localparam int unsigned ElW      = 16;
  localparam int unsigned SlopeW   = 20;

  // serial multiplier: operand width and number of iterations
  localparam int unsigned MulW   = 20;
  localparam int unsigned MulLen = MulW;
  localparam int unsigned CntW   = $clog2(MulLen);

  localparam logic [BeatW-1:0] BeatMax = {BeatW{1'b1}};

  localparam logic [SpeedW-1:0] BaseSpeedRst  = 16'd839;
  localparam logic [SpeedW-1:0] PeakSpeedRst  = 16'd8389;
  localparam logic [SlopeW-1:0] DecaySlopeRst = 20'd3221;

  localparam logic [1:0] CmdTick   = 2'd0;
  localparam logic [1:0] CmdBeat   = 2'd1;
  localparam logic [1:0] CmdRender = 2'd2;

  localparam logic [1:0] CfgBaseSpeed  = 2'd0;
  localparam logic [1:0] CfgPeakSpeed  = 2'd1;
  localparam logic [1:0] CfgDecaySlope = 2'd2;

  localparam logic [2:0] Sector0 = 3'd0;
  localparam logic [2:0] Sector1 = 3'd1;
  localparam logic [2:0] Sector2 = 3'd2;
  localparam logic [2:0] Sector3 = 3'd3;
  localparam logic [2:0] Sector4 = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_DEC,
    ST_SPEED,
    ST_MUL_ADV,
    ST_PHASE,
    ST_HUE6,
    ST_COLOR
  } state_e;

endpackage

// ----- hdl/beat_driven_hue_wheel_core.sv -----
`timescale 1ns / 1ps
// Beat driven hue wheel. Input items on the s_axis side carry a command in tuser: a tick
// advances the hue phase by elapsed time times the current speed, which decays linearly from
// the peak speed to the base speed after a beat; a beat clears the beat timer; a render
// returns one fully saturated RGB(W) color on the m_axis side for the phase plus the light's
// hue offset. A beat or an unused command is taken in the idle state alone. A render passes
// through the hue6 and color states, waiting in the latter for the output register to drain. A
// tick runs both products (slope times beat time, then elapsed time times speed) through one
// shift-add multiplier that consumes one multiplier bit per cycle. The output register lets a
// new item enter while a color still waits to be taken.
`include "assert_macros.svh"

module beat_driven_hue_wheel_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // fields from bit 0: elapsed_ms[15:0], hue_offset[39:16], channel_base[48:40],
  // has_white[49], zero fill
  input  logic [bdhw_pkg::InDataW-1:0]  s_axis_tdata_i,
  // fields from bit 0: cmd[1:0]
  input  logic [1:0]                    s_axis_tuser_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // fields from bit 0: red[7:0], green[15:8], blue[23:16], white[31:24],
  // white_valid[32], light_channel[41:33], zero fill
  output logic [bdhw_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [bdhw_pkg::CfgW-1:0]     cfg_data_i
);
  import bdhw_pkg::*;

  state_e state_q, state_d;

  logic [SpeedW-1:0]   base_q, peak_q;
  logic [SlopeW-1:0]   slope_q;
  logic [PhaseW-1:0]   phase_q, phase_d;
  logic [BeatW-1:0]    beat_q, beat_d;
  logic                out_valid_q, out_valid_d;

  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic [MulW-1:0]     mc_q, mc_d;
  logic [MulW-1:0]     hi_q, hi_d;
  logic [MulW-1:0]     mr_q, mr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [ElW-1:0]      el_q, el_d;
  logic [PhaseW-1:0]   hue_q, hue_d;
  logic [PhaseW+2:0]   s_q, s_d;
  logic [8:0]          chan_q, chan_d;
  logic                white_q, white_d;

  logic                in_acc;
  logic [ElW-1:0]      in_el;
  logic [PhaseW-1:0]   in_hue;
  logic [BeatW:0]      beat_sum;
  logic [BeatW-1:0]    beat_sat;
  logic [MulW:0]       mul_sum;
  logic [2*MulW-1:0]   prod;
  logic [31:0]         dec;
  logic [SpeedW-1:0]   raw_speed, speed;
  logic [2:0]          sector;
  logic [PhaseW-1:0]   frac;
  logic [31:0]         rise_full;
  logic [7:0]          rise, fall;
  logic [7:0]          red, green, blue;

  assign in_el  = s_axis_tdata_i[15:0];
  assign in_hue = s_axis_tdata_i[39:16];
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  assign beat_sum = {1'b0, beat_q} + {{(BeatW + 1 - ElW){1'b0}}, in_el};
  assign beat_sat = beat_sum[BeatW] ? BeatMax : beat_sum[BeatW-1:0];

  // one multiplier bit per cycle, product shifts down into mr
  assign mul_sum = {1'b0, hi_q} + (mr_q[0] ? {1'b0, mc_q} : '0);
  assign prod    = {hi_q, mr_q};

  assign dec = prod[39:8];
  always_comb begin
    raw_speed = '0;
    if (dec[31:16] == '0 && dec[15:0] < peak_q) begin
      raw_speed = peak_q - dec[15:0];
    end
    speed = (raw_speed > base_q) ? raw_speed : base_q;
  end

  assign sector    = s_q[PhaseW+2:PhaseW];
  assign frac      = s_q[PhaseW-1:0];
  // frac * 255, rounded half up to 8 bits
  assign rise_full = {frac, 8'b0} - {8'b0, frac} + 32'h0080_0000;
  assign rise      = rise_full[31:24];
  assign fall      = 8'd255 - rise;

  always_comb begin
    unique case (sector)
      Sector0: begin red = 8'd255; green = rise;   blue = 8'd0;   end
      Sector1: begin red = fall;   green = 8'd255; blue = 8'd0;   end
      Sector2: begin red = 8'd0;   green = 8'd255; blue = rise;   end
      Sector3: begin red = 8'd0;   green = fall;   blue = 8'd255; end
      Sector4: begin red = rise;   green = 8'd0;   blue = 8'd255; end
      default: begin red = 8'd255; green = 8'd0;   blue = fall;   end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    beat_d      = beat_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    mc_d        = mc_q;
    hi_d        = hi_q;
    mr_d        = mr_q;
    cnt_d       = cnt_q;
    el_d        = el_q;
    hue_d       = hue_q;
    s_d         = s_q;
    chan_d      = chan_q;
    white_d     = white_q;
    s_axis_tready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          unique case (s_axis_tuser_i)
            CmdTick: begin
              beat_d  = beat_sat;
              el_d    = in_el;
              mc_d    = slope_q;
              mr_d    = beat_sat;
              hi_d    = '0;
              cnt_d   = '0;
              state_d = ST_MUL_DEC;
            end
            CmdBeat: begin
              beat_d = '0;
            end
            CmdRender: begin
              hue_d   = phase_q + in_hue;
              chan_d  = s_axis_tdata_i[48:40];
              white_d = s_axis_tdata_i[49];
              state_d = ST_HUE6;
            end
            default: begin
              // unused command: drop
            end
          endcase
        end
      end
      ST_MUL_DEC, ST_MUL_ADV: begin
        hi_d  = mul_sum[MulW:1];
        mr_d  = {mul_sum[0], mr_q[MulW-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(MulLen - 1)) begin
          state_d = (state_q == ST_MUL_DEC) ? ST_SPEED : ST_PHASE;
        end
      end
      ST_SPEED: begin
        mc_d    = {{(MulW - SpeedW){1'b0}}, speed};
        mr_d    = {{(MulW - ElW){1'b0}}, el_q};
        hi_d    = '0;
        cnt_d   = '0;
        state_d = ST_MUL_ADV;
      end
      ST_PHASE: begin
        phase_d = phase_q + prod[PhaseW-1:0];
        state_d = ST_IDLE;
      end
      ST_HUE6: begin
        s_d     = {1'b0, hue_q, 2'b0} + {2'b0, hue_q, 1'b0};
        state_d = ST_COLOR;
      end
      ST_COLOR: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_data_d  = {6'b0, chan_q, white_q, 8'd0, blue, green, red};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      beat_q      <= '0;
      out_valid_q <= 1'b0;
      base_q      <= BaseSpeedRst;
      peak_q      <= PeakSpeedRst;
      slope_q     <= DecaySlopeRst;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      beat_q      <= beat_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgBaseSpeed:  base_q  <= cfg_data_i[SpeedW-1:0];
          CfgPeakSpeed:  peak_q  <= cfg_data_i[SpeedW-1:0];
          CfgDecaySlope: slope_q <= cfg_data_i[SlopeW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    mc_q       <= mc_d;
    hi_q       <= hi_d;
    mr_q       <= mr_d;
    cnt_q      <= cnt_d;
    el_q       <= el_d;
    hue_q      <= hue_d;
    s_q        <= s_d;
    chan_q     <= chan_d;
    white_q    <= white_d;
  end

  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tvalid_o = out_valid_q;

  `ASSERT_AT(a_cnt_range, clk_i, rst_ni,
    (state_q == ST_MUL_DEC || state_q == ST_MUL_ADV) |-> (cnt_q < CntW'(MulLen)))
  `ASSERT_AT(a_beat_on_accept, clk_i, rst_ni, !in_acc |=> $stable(beat_q))
  `ASSERT_AT(a_phase_on_update, clk_i, rst_ni, (state_q != ST_PHASE) |=> $stable(phase_q))
  `ASSERT_NEVER(a_busy_ready, clk_i, rst_ni, s_axis_tready_o && (state_q != ST_IDLE))

endmodule

// ----- tb/sv/hue_wheel_checker.sv -----
`timescale 1ns / 1ps

module hue_wheel_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bdhw_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic [1:0]                    s_axis_tuser_i,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  input  logic [bdhw_pkg::OutDataW-1:0] m_axis_tdata_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [bdhw_pkg::CfgW-1:0]     cfg_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import bdhw_pkg::*;

  typedef struct packed {
    logic [8:0] light_channel;
    logic       white_valid;
    logic [7:0] white;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } light_color_t;

  logic [SpeedW-1:0] base_reg;
  logic [SpeedW-1:0] peak_reg;
  logic [SlopeW-1:0] slope_reg;
  logic [PhaseW-1:0] hue_phase;
  logic [BeatW-1:0]  beat_ms;

  logic [ElW-1:0]    elapsed;
  logic [BeatW:0]    beat_sum;
  logic [31:0]       advance;
  light_color_t      want;
  light_color_t      color_q[$];

  // speed for a given beat time, in 2^-24 turn per ms
  function automatic logic [SpeedW-1:0] beat_speed(input logic [BeatW-1:0] ms);
    logic [39:0]       drop;
    logic [SpeedW-1:0] raw;
    drop = (40'(slope_reg) * 40'(ms)) >> 8;
    raw  = (drop < 40'(peak_reg)) ? peak_reg - drop[SpeedW-1:0] : '0;
    return (raw > base_reg) ? raw : base_reg;
  endfunction

  function automatic light_color_t wheel_color(input logic [PhaseW-1:0] hue);
    logic [26:0]  hue6;
    logic [31:0]  scaled;
    logic [7:0]   rise;
    logic [7:0]   fall;
    light_color_t c;
    hue6   = 27'(hue) * 27'd6;
    scaled = 32'(hue6[23:0]) * 32'd255 + 32'h0080_0000;
    rise   = scaled[31:24];
    fall   = 8'd255 - rise;
    c      = '0;
    case (hue6[26:24])
      Sector0: begin c.red = 8'd255; c.green = rise; end
      Sector1: begin c.red = fall; c.green = 8'd255; end
      Sector2: begin c.green = 8'd255; c.blue = rise; end
      Sector3: begin c.green = fall; c.blue = 8'd255; end
      Sector4: begin c.red = rise; c.blue = 8'd255; end
      default: begin c.red = 8'd255; c.blue = fall; end
    endcase
    return c;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_reg     = BaseSpeedRst;
      peak_reg     = PeakSpeedRst;
      slope_reg    = DecaySlopeRst;
      hue_phase    = '0;
      beat_ms      = '0;
      color_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgBaseSpeed:  base_reg  = cfg_data_i[SpeedW-1:0];
          CfgPeakSpeed:  peak_reg  = cfg_data_i[SpeedW-1:0];
          CfgDecaySlope: slope_reg = cfg_data_i[SlopeW-1:0];
          default: ;
        endcase
      end

      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (color_q.size() == 0) begin
          $display("%0t: unexpected color item, expected none, got %h",
                   $time, m_axis_tdata_i);
          fail_count_o++;
        end else begin
          want = color_q.pop_front();
          check_field("red", want.red, m_axis_tdata_i[7:0]);
          check_field("green", want.green, m_axis_tdata_i[15:8]);
          check_field("blue", want.blue, m_axis_tdata_i[23:16]);
          check_field("white", want.white, m_axis_tdata_i[31:24]);
          check_field("white_valid", want.white_valid, m_axis_tdata_i[32]);
          check_field("light_channel", want.light_channel, m_axis_tdata_i[41:33]);
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        elapsed = s_axis_tdata_i[15:0];
        case (s_axis_tuser_i)
          CmdTick: begin
            // saturate the beat timer, then advance at the new speed
            beat_sum  = {1'b0, beat_ms} + 21'(elapsed);
            beat_ms   = (beat_sum > 21'(BeatMax)) ? BeatMax : beat_sum[BeatW-1:0];
            advance   = 32'(elapsed) * 32'(beat_speed(beat_ms));
            hue_phase = hue_phase + advance[PhaseW-1:0];
          end
          CmdBeat: beat_ms = '0;
          CmdRender: begin
            want               = wheel_color(hue_phase + s_axis_tdata_i[39:16]);
            want.white         = 8'd0;
            want.white_valid   = s_axis_tdata_i[49];
            want.light_channel = s_axis_tdata_i[48:40];
            color_q.push_back(want);
          end
          default: ;
        endcase
      end
      pending_o = color_q.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import bdhw_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned SettleCycles  = 60;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned PhaseItems    = 95;
  localparam int unsigned HoldCycles    = 400;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam logic [1:0] CfgUnused = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic                cfg_we;
  logic [1:0]          cfg_idx;
  logic [CfgW-1:0]     cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_req;
  int unsigned quiet_cycles;

  always #5 clk = ~clk;

  beat_driven_hue_wheel_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  hue_wheel_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [InDataW-1:0] pack_item(input logic [15:0] el,
                                                   input logic [23:0] hue,
                                                   input logic [8:0] chan,
                                                   input logic white);
    return {6'b0, white, chan, hue, el};
  endfunction

  function automatic logic [InDataW-1:0] random_item();
    return pack_item(16'($urandom), 24'($urandom), 9'($urandom), 1'($urandom));
  endfunction

  function automatic logic [15:0] random_elapsed();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return 16'($urandom_range(200));
    if (pick < 85) return 16'($urandom);
    return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [InDataW-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  // a tick leaves no result behind, so let the block settle before touching registers
  task automatic wait_idle();
    drop_valid();
    wait (pending == 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_regs(input int unsigned base, input int unsigned peak,
                            input int unsigned slope);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgBaseSpeed;
    cfg_data <= {4'($urandom), 16'(base)};
    @(negedge clk);
    cfg_idx  <= CfgPeakSpeed;
    cfg_data <= {4'($urandom), 16'(peak)};
    @(negedge clk);
    cfg_idx  <= CfgDecaySlope;
    cfg_data <= 20'(slope);
    @(negedge clk);
    cfg_idx  <= CfgUnused;
    cfg_data <= 20'($urandom);
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic send_random_item();
    logic [InDataW-1:0] data;
    int unsigned        pick;
    pick = $urandom_range(99);
    data = random_item();
    if (pick < 45) begin
      send_item(CmdRender, data);
    end else if (pick < 75) begin
      data[15:0] = random_elapsed();
      send_item(CmdTick, data);
    end else if (pick < 88) begin
      send_item(CmdBeat, data);
    end else if (pick < 93) begin
      send_item(CmdUnused, data);
    end else begin
      // beat followed by a few short ticks, watching the decay
      send_item(CmdBeat, data);
      repeat (3) begin
        data       = random_item();
        data[15:0] = 16'($urandom_range(100));
        send_item(CmdTick, data);
        send_item(CmdRender, random_item());
      end
    end
  endtask

  initial begin
    int unsigned base_set[PhaseCount];
    int unsigned peak_set[PhaseCount];
    int unsigned slope_set[PhaseCount];
    int unsigned ph;
    int unsigned n;

    base_set  = '{839, 0, 65535, 0, $urandom_range(65535), 65535, $urandom_range(65535), 1};
    peak_set  = '{8389, 65535, 0, 0, $urandom_range(65535), 65535, $urandom_range(65535),
                  65535};
    slope_set = '{3221, 1048575, 0, 0, $urandom_range(1048575), 1, $urandom_range(1048575),
                  1048575};

    s_axis_tvalid  <= 1'b0;
    s_axis_tuser   <= CmdTick;
    s_axis_tdata   <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CfgBaseSpeed;
    cfg_data       <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    rst_n          <= 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: sector edges, field extremes, each command, ignored fields
    send_item(CmdRender, pack_item(16'h0000, 24'h000000, 9'd0, 1'b0));
    send_item(CmdRender, pack_item(16'hFFFF, 24'hFFFFFF, 9'd511, 1'b1));
    send_item(CmdRender, pack_item(16'h0000, 24'h2AAAAA, 9'd1, 1'b0));
    send_item(CmdRender, pack_item(16'h0000, 24'h2AAAAB, 9'd2, 1'b1));
    send_item(CmdRender, pack_item(16'h0000, 24'h555555, 9'd3, 1'b0));
    send_item(CmdRender, pack_item(16'h0000, 24'h555556, 9'd4, 1'b1));
    send_item(CmdRender, pack_item(16'h0000, 24'h800000, 9'd5, 1'b0));
    send_item(CmdRender, pack_item(16'h0000, 24'hAAAAAA, 9'd6, 1'b1));
    send_item(CmdRender, pack_item(16'h0000, 24'hAAAAAB, 9'd7, 1'b0));
    send_item(CmdRender, pack_item(16'h0000, 24'hD55555, 9'd8, 1'b1));
    send_item(CmdRender, pack_item(16'h0000, 24'hD55556, 9'd9, 1'b0));
    send_item(CmdTick, pack_item(16'h0000, 24'hFFFFFF, 9'd511, 1'b1));
    send_item(CmdRender, pack_item(16'h0000, 24'h000000, 9'd10, 1'b0));
    send_item(CmdTick, pack_item(16'hFFFF, 24'h000000, 9'd0, 1'b0));
    send_item(CmdRender, pack_item(16'h0000, 24'h000000, 9'd11, 1'b1));
    send_item(CmdBeat, pack_item(16'hFFFF, 24'hFFFFFF, 9'd511, 1'b1));
    send_item(CmdTick, pack_item(16'd1000, 24'h000000, 9'd0, 1'b0));
    send_item(CmdRender, pack_item(16'h0000, 24'h000000, 9'd12, 1'b0));
    send_item(CmdUnused, random_item());
    send_item(CmdRender, pack_item(16'h0000, 24'h000000, 9'd13, 1'b1));

    for (ph = 0; ph < PhaseCount; ph++) begin
      wait_idle();
      write_regs(base_set[ph], peak_set[ph], slope_set[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase

      for (n = 0; n < PhaseItems; n++) begin
        if (n == PhaseItems / 2) begin
          if (ph == 0) begin
            // hold the receiver off while renders keep coming, so the block backs up
            hold_req = HoldCycles;
            repeat (12) send_item(CmdRender, random_item());
          end else if (ph == 2) begin
            drop_valid();
            wait (pending == 0);
          end else if (ph == 1 || ph == 5) begin
            // run the beat timer into saturation
            repeat (18) send_item(CmdTick, pack_item(16'hFFFF, 24'($urandom), 9'($urandom),
                                                     1'($urandom)));
            send_item(CmdRender, random_item());
            send_item(CmdTick, pack_item(16'd50, 24'($urandom), 9'($urandom), 1'($urandom)));
            send_item(CmdRender, random_item());
          end
        end
        send_random_item();
      end
    end

    drop_valid();
    wait (pending == 0);
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- beat_driven_hue_wheel_core.f -----
+incdir+hdl
hdl/bdhw_pkg.sv
hdl/beat_driven_hue_wheel_core.sv
tb/sv/hue_wheel_checker.sv
tb/sv/tb.sv
